/* rtl/damped_wave_stencil_step_macros.svh */
// Assertion helpers shared by the stencil step block.
`ifndef DAMPED_WAVE_STENCIL_STEP_MACROS_SVH
`define DAMPED_WAVE_STENCIL_STEP_MACROS_SVH

// Same-cycle implication.
`define DWSS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define DWSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/dwss_pkg.sv */
package dwss_pkg;

   localparam int VAL_W     = 20;
   localparam int LAP_W     = 23;
   localparam int TWICE_W   = 22;
   localparam int ACC_W     = 40;
   localparam int IDX_W     = 7;
   localparam int CFG_W     = 16;
   localparam int CSR_IDX_W = 2;

   typedef logic signed [VAL_W-1:0] value_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WAVE_COEFF = 2'd0,
      CSR_DAMPING    = 2'd1
   } csr_index_type;

   localparam logic [CFG_W-1:0] WAVE_COEFF_RESET = 16'd15729;
   localparam logic [CFG_W-1:0] DAMPING_RESET    = 16'd65012;

   localparam value_type Q_MAX = 20'h7FFFF;
   localparam value_type Q_MIN = 20'h80000;

   // Up to two results per cell: 'a' for the cell one line behind,
   // 'b' for a cell of the last line itself (always a border result).
   typedef struct packed {
      logic             has_a;
      logic             a_border;
      logic [IDX_W-1:0] a_outer;
      value_type        a_prev;
      logic             has_b;
      logic [IDX_W-1:0] b_outer;
      value_type        b_prev;
      logic             b_last;
      logic [IDX_W-1:0] inner;
   } rsp_meta_type;

endpackage

/* rtl/dwss_cell.sv */
module dwss_cell (
   input  logic               clock,
   input  logic               shift_en,
   input  dwss_pkg::value_type shift_in,
   output dwss_pkg::value_type shift_out
);
   import dwss_pkg::*;

   value_type value_ff;
   value_type value_in;

   always_comb begin
      value_in = shift_en ? shift_in : value_ff;
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign shift_out = value_ff;

endmodule

/* rtl/dwss_arith.sv */
module dwss_arith (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 in_valid,
   input  logic signed [dwss_pkg::LAP_W-1:0]    in_lap,
   input  logic signed [dwss_pkg::TWICE_W-1:0]  in_twice,
   input  dwss_pkg::rsp_meta_type               in_meta,
   input  logic [dwss_pkg::CFG_W-1:0]           wave_coeff,
   input  logic [dwss_pkg::CFG_W-1:0]           damping,
   output logic                                 out_valid,
   output dwss_pkg::value_type                  out_next,
   output dwss_pkg::rsp_meta_type               out_meta
);
   import dwss_pkg::*;

   localparam int SPLIT = 20;
   localparam int HI_W  = ACC_W - SPLIT;
   localparam int PH_W  = HI_W + CFG_W + 1;
   localparam int PL_W  = SPLIT + CFG_W;
   localparam int TOT_W = 57;
   localparam int Q_W   = TOT_W - 32;
   localparam logic signed [TOT_W-1:0] RND      = 57'sd2147483648;
   localparam logic signed [Q_W-1:0]   Q_MAX_X  = 25'sd524287;
   localparam logic signed [Q_W-1:0]   Q_MIN_X  = -25'sd524288;

   logic                       valid1_ff, valid1_in;
   logic                       valid2_ff, valid2_in;
   logic                       valid3_ff, valid3_in;
   logic signed [LAP_W-1:0]    lap1_ff, lap1_in;
   logic signed [TWICE_W-1:0]  twice1_ff, twice1_in;
   rsp_meta_type               meta1_ff, meta1_in;
   logic signed [ACC_W-1:0]    acc2_ff, acc2_in;
   rsp_meta_type               meta2_ff, meta2_in;
   logic signed [PH_W-1:0]     prodh3_ff, prodh3_in;
   logic [PL_W-1:0]            prodl3_ff, prodl3_in;
   rsp_meta_type               meta3_ff, meta3_in;

   logic signed [CFG_W:0]      coeff_s;
   logic signed [CFG_W:0]      damp_s;
   logic signed [ACC_W-1:0]    wlap;
   logic signed [ACC_W-1:0]    acc_calc;
   logic signed [HI_W-1:0]     acc_hi;
   logic [SPLIT-1:0]           acc_lo;
   logic signed [PH_W-1:0]     prodh_calc;
   logic [PL_W-1:0]            prodl_calc;
   logic signed [TOT_W-1:0]    total;
   logic signed [Q_W-1:0]      rounded;

   // stage 2: acc = (2c - p) * 2^16 + coeff * lap
   always_comb begin
      coeff_s  = $signed({1'b0, wave_coeff});
      wlap     = coeff_s * lap1_ff;
      acc_calc = (ACC_W'(twice1_ff) <<< 16) + wlap;
   end

   // stage 3: acc * damping as two partial products
   always_comb begin
      damp_s     = $signed({1'b0, damping});
      acc_hi     = acc2_ff[ACC_W-1:SPLIT];
      acc_lo     = acc2_ff[SPLIT-1:0];
      prodh_calc = acc_hi * damp_s;
      prodl_calc = acc_lo * damping;
   end

   // final: recombine, round to nearest, saturate
   always_comb begin
      total   = (TOT_W'(prodh3_ff) <<< SPLIT) + $signed(TOT_W'(prodl3_ff)) + RND;
      rounded = $signed(total[TOT_W-1:32]);
      if (rounded > Q_MAX_X) begin
         out_next = Q_MAX;
      end else if (rounded < Q_MIN_X) begin
         out_next = Q_MIN;
      end else begin
         out_next = rounded[VAL_W-1:0];
      end
   end

   always_comb begin
      valid1_in = valid1_ff;
      valid2_in = valid2_ff;
      valid3_in = valid3_ff;
      lap1_in   = lap1_ff;
      twice1_in = twice1_ff;
      meta1_in  = meta1_ff;
      acc2_in   = acc2_ff;
      meta2_in  = meta2_ff;
      prodh3_in = prodh3_ff;
      prodl3_in = prodl3_ff;
      meta3_in  = meta3_ff;
      if (advance) begin
         valid1_in = in_valid;
         valid2_in = valid1_ff;
         valid3_in = valid2_ff;
         lap1_in   = in_lap;
         twice1_in = in_twice;
         meta1_in  = in_meta;
         acc2_in   = acc_calc;
         meta2_in  = meta1_ff;
         prodh3_in = prodh_calc;
         prodl3_in = prodl_calc;
         meta3_in  = meta2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
         valid2_ff <= valid2_in;
         valid3_ff <= valid3_in;
      end
   end

   always_ff @(posedge clock) begin
      lap1_ff   <= lap1_in;
      twice1_ff <= twice1_in;
      meta1_ff  <= meta1_in;
      acc2_ff   <= acc2_in;
      meta2_ff  <= meta2_in;
      prodh3_ff <= prodh3_in;
      prodl3_ff <= prodl3_in;
      meta3_ff  <= meta3_in;
   end

   assign out_valid = valid3_ff;
   assign out_meta  = meta3_ff;

endmodule

/* rtl/damped_wave_stencil_step.sv */
// Damped wave stencil step. Grid cells stream in raster order (inner index
// fastest), one transaction per cell, with frame_start on the first cell of a
// pass. Each accepted cell finishes the cell one line behind it and returns
// its next amplitude and new previous amplitude; cells of the first line
// return nothing and cells of the last line return two results (the line
// behind, then the cell itself as a border result). The block takes one cell
// per clock while the result port does not stall, except on the last line of
// a pass, where a cell's second result holds off the next cell. Results pass
// through the arithmetic pipeline and the result register. Line storage is a
// chain of 3*GRID_INNER shift cells (two lines of current values, one line of
// previous values) that advances once per accepted cell, so no clearing is
// needed after reset. The user must write wave_coeff and damping through the
// csr port only while no transaction is in flight; the block does not enforce it.
`include "damped_wave_stencil_step_macros.svh"

module damped_wave_stencil_step #(
   parameter int GRID_INNER = 128,
   parameter int GRID_OUTER = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [dwss_pkg::VAL_W-1:0] req_cur_value,
   input  logic signed [dwss_pkg::VAL_W-1:0] req_prev_value,
   input  logic                              req_frame_start,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [dwss_pkg::IDX_W-1:0]        rsp_out_outer,
   output logic [dwss_pkg::IDX_W-1:0]        rsp_out_inner,
   output logic signed [dwss_pkg::VAL_W-1:0] rsp_next_value,
   output logic signed [dwss_pkg::VAL_W-1:0] rsp_new_prev_value,
   output logic                              rsp_frame_last,
   input  logic                              csr_wr_en,
   input  logic [dwss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dwss_pkg::CFG_W-1:0]        csr_wr_data
);
   import dwss_pkg::*;

   localparam int N   = GRID_INNER;
   localparam int OW  = $clog2(GRID_OUTER);
   localparam int IW  = $clog2(GRID_INNER);
   localparam int OEW = (OW > IDX_W) ? OW : IDX_W;
   localparam int IEW = (IW > IDX_W) ? IW : IDX_W;

   logic [CFG_W-1:0] wave_coeff_ff, wave_coeff_in;
   logic [CFG_W-1:0] damping_ff, damping_in;
   logic [OW-1:0]    outer_ff, outer_in;
   logic [IW-1:0]    inner_ff, inner_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] out_outer_ff, out_outer_in;
   logic [IDX_W-1:0] out_inner_ff, out_inner_in;
   value_type        next_ff, next_in;
   value_type        new_prev_ff, new_prev_in;
   logic             last_ff, last_in;
   logic             b_pend_ff, b_pend_in;
   rsp_meta_type     b_meta_ff, b_meta_in;

   logic             out_free;
   logic             advance;
   logic             accept;

   value_type        cur_chain  [2*N+1];
   value_type        prev_chain [N+1];

   logic [OW-1:0]    pos_outer;
   logic [IW-1:0]    pos_inner;
   logic [OW-1:0]    row_back;
   logic [OEW-1:0]   pos_outer_x;
   logic [OEW-1:0]   row_back_x;
   logic [IEW-1:0]   pos_inner_x;
   logic signed [LAP_W-1:0]   lap_s0;
   logic signed [TWICE_W-1:0] twice_s0;
   rsp_meta_type     meta_s0;

   logic             arith_valid;
   value_type        arith_next;
   rsp_meta_type     arith_meta;

   // line storage
   assign cur_chain[0]  = req_cur_value;
   assign prev_chain[0] = req_prev_value;

   for (genvar k = 0; k < 2*N; k++) begin : g_cur
      dwss_cell u_cell (
         .clock     (clock),
         .shift_en  (accept),
         .shift_in  (cur_chain[k]),
         .shift_out (cur_chain[k+1])
      );
   end

   for (genvar k = 0; k < N; k++) begin : g_prev
      dwss_cell u_cell (
         .clock     (clock),
         .shift_en  (accept),
         .shift_in  (prev_chain[k]),
         .shift_out (prev_chain[k+1])
      );
   end

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = out_free && !b_pend_ff;
   assign accept    = req_valid && advance;
   assign req_stall = !advance;

   // position of the arriving cell
   always_comb begin
      pos_outer   = req_frame_start ? '0 : outer_ff;
      pos_inner   = req_frame_start ? '0 : inner_ff;
      row_back    = pos_outer - 1'b1;
      pos_outer_x = OEW'(pos_outer);
      row_back_x  = OEW'(row_back);
      pos_inner_x = IEW'(pos_inner);
   end

   always_comb begin
      outer_in = outer_ff;
      inner_in = inner_ff;
      if (accept) begin
         if (pos_inner == IW'(GRID_INNER - 1)) begin
            inner_in = '0;
            outer_in = (pos_outer == OW'(GRID_OUTER - 1)) ? '0 : pos_outer + 1'b1;
         end else begin
            inner_in = pos_inner + 1'b1;
            outer_in = pos_outer;
         end
      end
   end

   // stencil taps: down the arriving cell, right N-1, center N, left N+1, up 2N cells back
   always_comb begin
      lap_s0 = LAP_W'(cur_chain[2*N]) + LAP_W'(req_cur_value)
             + LAP_W'(cur_chain[N+1]) + LAP_W'(cur_chain[N-1])
             - (LAP_W'(cur_chain[N]) <<< 2);
      twice_s0 = (TWICE_W'(cur_chain[N]) <<< 1) - TWICE_W'(prev_chain[N]);
   end

   always_comb begin
      meta_s0.has_a    = (pos_outer != '0);
      meta_s0.a_border = (row_back == '0) || (pos_inner == '0)
                      || (pos_inner == IW'(GRID_INNER - 1));
      meta_s0.a_outer  = row_back_x[IDX_W-1:0];
      meta_s0.a_prev   = cur_chain[N];
      meta_s0.has_b    = (pos_outer == OW'(GRID_OUTER - 1));
      meta_s0.b_outer  = pos_outer_x[IDX_W-1:0];
      meta_s0.b_prev   = req_cur_value;
      meta_s0.b_last   = (pos_inner == IW'(GRID_INNER - 1));
      meta_s0.inner    = pos_inner_x[IDX_W-1:0];
   end

   dwss_arith u_arith (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (accept),
      .in_lap     (lap_s0),
      .in_twice   (twice_s0),
      .in_meta    (meta_s0),
      .wave_coeff (wave_coeff_ff),
      .damping    (damping_ff),
      .out_valid  (arith_valid),
      .out_next   (arith_next),
      .out_meta   (arith_meta)
   );

   // configuration
   always_comb begin
      wave_coeff_in = wave_coeff_ff;
      damping_in    = damping_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_WAVE_COEFF: begin
               wave_coeff_in = csr_wr_data;
            end
            CSR_DAMPING: begin
               damping_in = csr_wr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // result register; a second result waits in b_meta
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_outer_in = out_outer_ff;
      out_inner_in = out_inner_ff;
      next_in      = next_ff;
      new_prev_in  = new_prev_ff;
      last_in      = last_ff;
      b_pend_in    = b_pend_ff;
      b_meta_in    = advance ? arith_meta : b_meta_ff;
      if (out_free) begin
         if (b_pend_ff) begin
            rsp_valid_in = 1'b1;
            out_outer_in = b_meta_ff.b_outer;
            out_inner_in = b_meta_ff.inner;
            next_in      = '0;
            new_prev_in  = b_meta_ff.b_prev;
            last_in      = b_meta_ff.b_last;
            b_pend_in    = 1'b0;
         end else if (arith_valid && arith_meta.has_a) begin
            rsp_valid_in = 1'b1;
            out_outer_in = arith_meta.a_outer;
            out_inner_in = arith_meta.inner;
            next_in      = arith_meta.a_border ? '0 : arith_next;
            new_prev_in  = arith_meta.a_prev;
            last_in      = 1'b0;
            b_pend_in    = arith_meta.has_b;
         end else if (arith_valid && arith_meta.has_b) begin
            rsp_valid_in = 1'b1;
            out_outer_in = arith_meta.b_outer;
            out_inner_in = arith_meta.inner;
            next_in      = '0;
            new_prev_in  = arith_meta.b_prev;
            last_in      = arith_meta.b_last;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_coeff_ff <= WAVE_COEFF_RESET;
         damping_ff    <= DAMPING_RESET;
         outer_ff      <= '0;
         inner_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         b_pend_ff     <= 1'b0;
      end else begin
         wave_coeff_ff <= wave_coeff_in;
         damping_ff    <= damping_in;
         outer_ff      <= outer_in;
         inner_ff      <= inner_in;
         rsp_valid_ff  <= rsp_valid_in;
         b_pend_ff     <= b_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      out_outer_ff <= out_outer_in;
      out_inner_ff <= out_inner_in;
      next_ff      <= next_in;
      new_prev_ff  <= new_prev_in;
      last_ff      <= last_in;
      b_meta_ff    <= b_meta_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_outer      = out_outer_ff;
   assign rsp_out_inner      = out_inner_ff;
   assign rsp_next_value     = next_ff;
   assign rsp_new_prev_value = new_prev_ff;
   assign rsp_frame_last     = last_ff;

   `DWSS_ASSERT_SAME(a_pend_needs_held, clock, reset, b_pend_ff, rsp_valid_ff, "second result pending without a held result")
   `DWSS_ASSERT_SAME(a_last_is_border, clock, reset, rsp_valid_ff && rsp_frame_last, rsp_next_value == '0 && !b_pend_ff, "frame_last result is not a final border result")
   `DWSS_ASSERT_NEXT(a_pend_follows, clock, reset, rsp_valid_ff && !rsp_stall && b_pend_ff, rsp_valid_ff && rsp_next_value == '0, "pending border result did not follow")

endmodule
